/* rtl/haversine_distance_defines.svh */
// Assertion macros shared by the haversine distance checker.
// No dependencies.
`ifndef HAVERSINE_DISTANCE_DEFINES_SVH
`define HAVERSINE_DISTANCE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define HD_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HD_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

/* rtl/hvd_pkg.sv */
// Package for the haversine distance pipeline: constants and the CORDIC angle table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hvd_pkg;
	localparam int NITER = 30;
	localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	// One turn is 3.6e9 units of 1e-7 degree, which is 2^10 times the odd factor below.
	localparam logic [21:0] TURN_ODD = 22'd3515625;
	// ceil(2^55 / TURN_ODD): exact floor division of any 33-bit value by TURN_ODD.
	localparam logic [33:0] TURN_RECIP = 34'd10248191153;
	// Half a turn divided by 2^10, rounded down; it gives round to nearest.
	localparam logic [32:0] TURN_BIAS = 33'd1757812;
	localparam logic [23:0] RADIUS_RST = 24'd6378100;

	function automatic logic signed [33:0] atan_q30(input int i);
		logic signed [33:0] r;
		begin
			case (i)
				0: r = 34'sd843314856;
				1: r = 34'sd497837829;
				2: r = 34'sd263043836;
				3: r = 34'sd133525158;
				4: r = 34'sd67021686;
				5: r = 34'sd33543515;
				6: r = 34'sd16775850;
				7: r = 34'sd8388437;
				8: r = 34'sd4194282;
				9: r = 34'sd2097149;
				default: r = 34'sd1 <<< (30 - i);
			endcase
			if (i >= 10) r = r - 34'sd1;
			return r;
		end
	endfunction
endpackage
`default_nettype wire

/* rtl/haversine_distance.sv */
// Top level of the haversine great-circle distance pipeline.
// Depends on hvd_pkg and hvd_core.
//
// Usage: one point pair enters on the input channel (in_valid / in_stall)
// and one distance in millimetres leaves on the output channel
// (out_valid / out_stall). An item is taken at any edge where valid is
// high and stall is low. The pipeline accepts one item every cycle while
// it is not stalled. The core has 111 register stages: angle mapping with
// a three-digit reciprocal division (9), two thirty-step unrolled CORDIC
// chains with their set-up stages, products and clamp, a bit-per-stage
// square root (32) and the radius scaling (3).
// When the receiver stalls with a result waiting, the whole pipeline freezes
// and in_stall is raised, so nothing is lost or repeated. Reset clears all
// valid bits and loads the radius with 6378100 m. The user must write the
// radius through cfg_we / cfg_wdata only while idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none
module haversine_distance (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [23:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [30:0] lat_a,
	input wire logic signed [31:0] lon_a,
	input wire logic signed [30:0] lat_b,
	input wire logic signed [31:0] lon_b,
	output logic out_valid,
	input wire logic out_stall,
	output logic [35:0] distance_mm
);
	import hvd_pkg::*;
	logic [23:0] radius_q;
	logic en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end
	// The pipeline advances unless a finished result is held by the receiver.
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	hvd_core u_core (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(in_valid),
		.lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
		.radius(radius_q), .v_out(out_valid), .dist_mm(distance_mm)
	);
endmodule
`default_nettype wire

/* rtl/hvd_core.sv */
// Datapath of the haversine pipeline: angle mapping, CORDIC, square roots, scaling.
// Depends on hvd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hvd_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic v_in,
	input wire logic signed [30:0] lat_a,
	input wire logic signed [31:0] lon_a,
	input wire logic signed [30:0] lat_b,
	input wire logic signed [31:0] lon_b,
	input wire logic [23:0] radius,
	output logic v_out,
	output logic [35:0] dist_mm
);
	import hvd_pkg::*;

	// Angle mapping 9, rotation 1 + NITER, select 1, products and clamp 4,
	// square root 1 + 31, vectoring 1 + NITER, scaling 3.
	localparam int NS = 9 + 1 + NITER + 1 + 4 + 1 + 31 + 1 + NITER + 3;
	logic [NS-1:0] v_q;

	// Stage 1: differences; stage 2: modular reduction to [0, d).
	logic signed [33:0] dlat_s1, dlon_s1, la_s1, lb_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s1 <= 34'(lat_b) - 34'(lat_a);
			dlon_s1 <= 34'(lon_b) - 34'(lon_a);
			la_s1 <= 34'(lat_a);
			lb_s1 <= 34'(lat_b);
		end
	end

	function automatic logic [33:0] red(input logic signed [33:0] u, input logic half);
		logic signed [35:0] d, r;
		begin
			d = half ? 36'sd7200000000 : 36'sd3600000000;
			r = 36'(u);
			if (r < 0) r = r + d;
			if (r < 0) r = r + d;
			if (r >= d) r = r - d;
			if (r >= d) r = r - d;
			return r[33:0];
		end
	endfunction

	logic [33:0] r_s2 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			r_s2[0] <= red(dlat_s1, 1'b1);
			r_s2[1] <= red(dlon_s1, 1'b1);
			r_s2[2] <= red(la_s1, 1'b0);
			r_s2[3] <= red(lb_s1, 1'b0);
		end
	end

	// Stages 3 to 8: binary angle = floor((r*2^k + 1.8e9)/3.6e9). The divisor is 2^10 times
	// an odd constant, so the quotient is built from three long-division digits of 11 bits,
	// each found by a reciprocal multiply that is exact for numerators below 2^33.
	logic [32:0] r_s3 [4];
	logic [66:0] dp_s3 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				r_s3[k] <= r_s2[k][32:0];
				dp_s3[k] <= 67'(r_s2[k][32:0]) * 67'(TURN_RECIP);
			end
		end
	end
	logic [11:0] qa_s4 [4];
	logic [32:0] n_s4 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				logic [11:0] qd;
				logic [32:0] rm;
				qd = dp_s3[k][66:55];
				rm = r_s3[k] - 33'(qd) * 33'(TURN_ODD);
				qa_s4[k] <= qd;
				n_s4[k] <= {rm[21:0], 11'd0};
			end
		end
	end
	logic [11:0] qa_s5 [4];
	logic [32:0] n_s5 [4];
	logic [66:0] dp_s5 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				qa_s5[k] <= qa_s4[k];
				n_s5[k] <= n_s4[k];
				dp_s5[k] <= 67'(n_s4[k]) * 67'(TURN_RECIP);
			end
		end
	end
	logic [11:0] qa_s6 [4], qb_s6 [4];
	logic [32:0] n_s6 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				logic [11:0] qd;
				logic [32:0] rm;
				qd = dp_s5[k][66:55];
				rm = n_s5[k] - 33'(qd) * 33'(TURN_ODD);
				qa_s6[k] <= qa_s5[k];
				qb_s6[k] <= qd;
				// Half angles keep one bit less of the last digit.
				n_s6[k] <= ((k < 2) ? {1'b0, rm[21:0], 10'd0} : {rm[21:0], 11'd0}) + TURN_BIAS;
			end
		end
	end
	logic [11:0] qa_s7 [4], qb_s7 [4];
	logic [66:0] dp_s7 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				qa_s7[k] <= qa_s6[k];
				qb_s7[k] <= qb_s6[k];
				dp_s7[k] <= 67'(n_s6[k]) * 67'(TURN_RECIP);
			end
		end
	end
	logic [31:0] bam_s8 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				logic [11:0] qd;
				qd = dp_s7[k][66:55];
				if (k < 2) begin
					bam_s8[k] <= ({20'd0, qa_s7[k]} << 21) + ({20'd0, qb_s7[k]} << 10)
					             + {20'd0, qd};
				end else begin
					bam_s8[k] <= ({20'd0, qa_s7[k]} << 22) + ({20'd0, qb_s7[k]} << 11)
					             + {20'd0, qd};
				end
			end
		end
	end

	// Quadrant removal and scaling to Q2.30 radians.
	logic [1:0] q_s9 [4];
	logic signed [63:0] pz_s9 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				logic [31:0] rem;
				logic [1:0] qq;
				qq = 2'((bam_s8[k] + 32'h2000_0000) >> 30);
				rem = bam_s8[k] - {qq, 30'd0};
				q_s9[k] <= qq;
				pz_s9[k] <= 64'($signed(rem)) * $signed({1'b0, PI_Q30});
			end
		end
	end

	// Rotation CORDIC, one step per stage, four lanes.
	logic signed [33:0] x_r [NITER+1][4], y_r [NITER+1][4], z_r [NITER+1][4];
	logic [1:0] q_r [NITER+1][4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				x_r[0][k] <= CORDIC_K;
				y_r[0][k] <= '0;
				z_r[0][k] <= 34'((pz_s9[k] + 64'sd1073741824) >>> 31);
				q_r[0][k] <= q_s9[k];
			end
		end
	end
	for (genvar i = 0; i < NITER; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 4; k++) begin
					if (z_r[i][k] >= 0) begin
						x_r[i+1][k] <= x_r[i][k] - (y_r[i][k] >>> i);
						y_r[i+1][k] <= y_r[i][k] + (x_r[i][k] >>> i);
						z_r[i+1][k] <= z_r[i][k] - atan_q30(i);
					end else begin
						x_r[i+1][k] <= x_r[i][k] + (y_r[i][k] >>> i);
						y_r[i+1][k] <= y_r[i][k] - (x_r[i][k] >>> i);
						z_r[i+1][k] <= z_r[i][k] + atan_q30(i);
					end
					q_r[i+1][k] <= q_r[i][k];
				end
			end
		end
	end

	function automatic logic signed [33:0] qsel(input logic [1:0] q,
			input logic signed [33:0] x, input logic signed [33:0] y, input logic want_sin);
		logic signed [33:0] s, c;
		begin
			case (q)
				2'd0: begin s = y; c = x; end
				2'd1: begin s = x; c = -y; end
				2'd2: begin s = -y; c = -x; end
				default: begin s = -x; c = y; end
			endcase
			return want_sin ? s : c;
		end
	endfunction

	logic signed [33:0] s1_s6, s2_s6, c1_s6, c2_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			s1_s6 <= qsel(q_r[NITER][0], x_r[NITER][0], y_r[NITER][0], 1'b1);
			s2_s6 <= qsel(q_r[NITER][1], x_r[NITER][1], y_r[NITER][1], 1'b1);
			c1_s6 <= qsel(q_r[NITER][2], x_r[NITER][2], y_r[NITER][2], 1'b0);
			c2_s6 <= qsel(q_r[NITER][3], x_r[NITER][3], y_r[NITER][3], 1'b0);
		end
	end

	// Products for a, at most two multiplies per stage.
	logic signed [67:0] cc_s7, ss_s7;
	logic signed [33:0] s2_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			cc_s7 <= 68'(c1_s6) * 68'(c2_s6);
			ss_s7 <= 68'(s1_s6) * 68'(s1_s6);
			s2_s7 <= s2_s6;
		end
	end
	logic signed [67:0] cs_s8, ss_s8;
	logic signed [33:0] s2_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			cs_s8 <= 68'(38'((cc_s7 + 68'sd536870912) >>> 30)) * 68'(s2_s7);
			ss_s8 <= ss_s7;
			s2_s8 <= s2_s7;
		end
	end
	logic signed [67:0] a_s9;
	always_ff @(posedge clk) begin
		if (en) a_s9 <= ss_s8 + 68'(40'((cs_s8 + 68'sd536870912) >>> 30)) * 68'(s2_s8);
	end
	logic [60:0] a_s10, b_s10;
	always_ff @(posedge clk) begin
		if (en) begin
			logic [60:0] ac;
			if (a_s9 < 0) ac = '0;
			else if (a_s9 > (68'sd1 <<< 60)) ac = 61'd1 << 60;
			else ac = 61'(a_s9);
			a_s10 <= ac;
			b_s10 <= (61'd1 << 60) - ac;
		end
	end

	// Pipelined integer square roots, one result bit per stage.
	logic [61:0] va_r [32], vb_r [32];
	logic [31:0] ra_r [32], rb_r [32];
	always_ff @(posedge clk) begin
		if (en) begin
			va_r[0] <= 62'(a_s10); vb_r[0] <= 62'(b_s10);
			ra_r[0] <= '0; rb_r[0] <= '0;
		end
	end
	for (genvar j = 0; j < 31; j++) begin : g_sq
		localparam int SH = 60 - 2 * j;
		always_ff @(posedge clk) begin
			if (en) begin
				logic [63:0] ta, tb;
				// Trial value: partial root placed above the new bit, plus the new bit squared.
				ta = ({32'd0, ra_r[j]} << (SH + 2)) + (64'd1 << SH);
				tb = ({32'd0, rb_r[j]} << (SH + 2)) + (64'd1 << SH);
				if ({2'b0, va_r[j]} >= ta) begin
					va_r[j+1] <= 62'({2'b0, va_r[j]} - ta); ra_r[j+1] <= (ra_r[j] << 1) | 32'd1;
				end else begin
					va_r[j+1] <= va_r[j]; ra_r[j+1] <= ra_r[j] << 1;
				end
				if ({2'b0, vb_r[j]} >= tb) begin
					vb_r[j+1] <= 62'({2'b0, vb_r[j]} - tb); rb_r[j+1] <= (rb_r[j] << 1) | 32'd1;
				end else begin
					vb_r[j+1] <= vb_r[j]; rb_r[j+1] <= rb_r[j] << 1;
				end
			end
		end
	end
	logic signed [33:0] vx_r [NITER+1], vy_r [NITER+1], vz_r [NITER+1];
	always_ff @(posedge clk) begin
		if (en) begin
			vx_r[0] <= 34'(rb_r[31]) + ((62'(vb_r[31]) > 62'(rb_r[31])) ? 34'sd1 : 34'sd0);
			vy_r[0] <= 34'(ra_r[31]) + ((62'(va_r[31]) > 62'(ra_r[31])) ? 34'sd1 : 34'sd0);
			vz_r[0] <= '0;
		end
	end
	for (genvar i = 0; i < NITER; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				if (vy_r[i] >= 0) begin
					vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
					vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
					vz_r[i+1] <= vz_r[i] + atan_q30(i);
				end else begin
					vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
					vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
					vz_r[i+1] <= vz_r[i] - atan_q30(i);
				end
			end
		end
	end

	// Scaling by radius and millimetres.
	logic [55:0] p_s11;
	always_ff @(posedge clk) begin
		if (en) p_s11 <= {32'd0, radius} * ((vz_r[NITER] < 0) ? 56'd0 : 56'(vz_r[NITER]));
	end
	logic [65:0] hi_s12, lo_s12;
	always_ff @(posedge clk) begin
		if (en) begin
			hi_s12 <= 66'(p_s11 >> 29) * 66'd1000;
			lo_s12 <= 66'(p_s11[28:0]) * 66'd1000;
		end
	end
	always_ff @(posedge clk) begin
		if (en) dist_mm <= 36'(hi_s12 + ((lo_s12 + (66'd1 << 28)) >> 29));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NS-2:0], v_in};
		end
	end
	assign v_out = v_q[NS-1];
endmodule
`default_nettype wire

/* rtl/hvd_checker.sv */
// Port-level checker for the haversine pipeline, bound to the top level.
// Depends on haversine_distance_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "haversine_distance_defines.svh"
module hvd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [35:0] distance_mm
);
	`HD_ASSERT_IMPL(a_stall_link, clk, arst_n, in_stall, out_valid && out_stall)
	`HD_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(distance_mm))
	`HD_ASSERT_IMPL(a_free, clk, arst_n, !out_valid, !in_stall)
endmodule
bind haversine_distance hvd_checker u_chk (.*);
`default_nettype wire
